// ===== rtl/pvp_pkg.sv =====
package pvp_pkg;

  // Quotient bits resolved by the divider; anything at or above 2^31 saturates
  localparam int QBITS = 31;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_X_SCALE      = 2'd0,
    CFG_Y_SCALE      = 2'd1,
    CFG_DEPTH_SCALE  = 2'd2,
    CFG_DEPTH_OFFSET = 2'd3
  } cfg_idx_t;

  localparam logic [31:0] X_SCALE_RST      = 32'h0001_0000;
  localparam logic [31:0] Y_SCALE_RST      = 32'h0001_0000;
  localparam logic [31:0] DEPTH_SCALE_RST  = 32'hFFFF_0000;
  localparam logic [31:0] DEPTH_OFFSET_RST = 32'h0000_0000;

  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic signed [31:0] vert_w;
  } vert_t;

  typedef struct packed {
    logic signed [31:0] proj_x;
    logic signed [31:0] proj_y;
    logic signed [31:0] proj_z;
    logic signed [31:0] proj_w;
    logic               zero_w;
  } proj_t;

  // Per-vertex info that rides alongside the divider
  typedef struct packed {
    logic [2:0]  neg;     // quotient sign per lane
    logic [2:0]  sat;     // quotient magnitude >= 2^31 per lane
    logic        zero;    // clip w is zero
    logic [31:0] cw_out;  // clip w, already clamped for the result field
  } side_t;

  typedef struct packed {
    logic [2:0][63:0] num;  // numerator magnitudes
    logic [31:0]      den;  // |cw|, at most 2^31
    side_t            side;
  } div_in_t;

  typedef struct packed {
    logic [2:0][QBITS-1:0] quo;
    side_t                 side;
  } div_out_t;

endpackage

// ===== rtl/perspective_vertex_projection.sv =====
// Channel   Signals                          Transaction
// vert      vert_valid / vert_ready / vert   one homogeneous vertex in
// proj      proj_valid / proj_ready / proj   one projected vertex out
// cfg       cfg_we / cfg_index / cfg_data    one coefficient write
//
// Takes one vertex per cycle unless proj_ready stalls the output; stages are multiply,
// magnitude/sum, saturation check, 31 divider stages and the output register.
// The divider resolves one quotient bit per stage for all lanes.
// Synchronous reset clears all valid bits and loads default coefficients.
// Every stage holds only while full and blocked, so bubbles close up under stall.
module perspective_vertex_projection (
  input  logic                clk,
  input  logic                rst,
  input  logic                vert_valid,
  output logic                vert_ready,
  input  pvp_pkg::vert_t      vert,
  output logic                proj_valid,
  input  logic                proj_ready,
  output pvp_pkg::proj_t      proj,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  logic signed [31:0] x_scale, y_scale, depth_scale, depth_offset;

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_scale      <= pvp_pkg::X_SCALE_RST;
      y_scale      <= pvp_pkg::Y_SCALE_RST;
      depth_scale  <= pvp_pkg::DEPTH_SCALE_RST;
      depth_offset <= pvp_pkg::DEPTH_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (pvp_pkg::cfg_idx_t'(cfg_index))
        pvp_pkg::CFG_X_SCALE:      x_scale      <= cfg_data;
        pvp_pkg::CFG_Y_SCALE:      y_scale      <= cfg_data;
        pvp_pkg::CFG_DEPTH_SCALE:  depth_scale  <= cfg_data;
        pvp_pkg::CFG_DEPTH_OFFSET: depth_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage handshake
  logic v1, v2, v3, vo;
  logic en1, en2, en3, eno;
  logic div_in_ready, div_out_valid;
  pvp_pkg::div_in_t  div_in;
  pvp_pkg::div_out_t div_out;

  assign eno        = !vo || proj_ready;
  assign en3        = !v3 || div_in_ready;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign vert_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (en1) v1 <= vert_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (eno) vo <= div_out_valid;
    end
  end

  // Stage 1: products and clip w
  logic signed [63:0] s1_px, s1_py, s1_pz, s1_pw;
  logic signed [32:0] s1_cw;
  logic               s1_zero;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_px   <= x_scale * vert.vert_x;
      s1_py   <= y_scale * vert.vert_y;
      s1_pz   <= depth_scale * vert.vert_z;
      s1_pw   <= depth_offset * vert.vert_w;
      s1_cw   <= -{vert.vert_z[31], vert.vert_z};
      s1_zero <= (vert.vert_z == '0);
    end
  end

  // Stage 2: exact depth sum and sign/magnitude split
  logic signed [64:0] s1_sum;
  logic [2:0][63:0]   s2_mag;
  logic [31:0]        s2_den;
  logic [2:0]         s2_neg;
  logic               s2_zero;
  logic [31:0]        s2_cw_out;

  assign s1_sum = {s1_pz[63], s1_pz} + {s1_pw[63], s1_pw};

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_mag[0] <= s1_px[63] ? 64'(-s1_px) : 64'(s1_px);
      s2_mag[1] <= s1_py[63] ? 64'(-s1_py) : 64'(s1_py);
      s2_mag[2] <= s1_sum[64] ? 64'(-s1_sum) : 64'(s1_sum);
      s2_den    <= s1_cw[32] ? 32'(-s1_cw) : 32'(s1_cw);
      s2_neg[0] <= s1_px[63] ^ s1_cw[32];
      s2_neg[1] <= s1_py[63] ^ s1_cw[32];
      s2_neg[2] <= s1_sum[64] ^ s1_cw[32];
      s2_zero   <= s1_zero;
      // only cw = 2^31 exceeds the signed range
      s2_cw_out <= (!s1_cw[32] && s1_cw[31]) ? pvp_pkg::SAT_POS : s1_cw[31:0];
    end
  end

  // Stage 3: saturation check, quotient >= 2^31
  always_ff @(posedge clk) begin
    if (en3) begin
      div_in.num         <= s2_mag;
      div_in.den         <= s2_den;
      div_in.side.neg    <= s2_neg;
      div_in.side.zero   <= s2_zero;
      div_in.side.cw_out <= s2_cw_out;
      for (int i = 0; i < 3; i++) begin
        div_in.side.sat[i] <= (s2_mag[i] >= {1'b0, s2_den, 31'b0});
      end
    end
  end

  pvp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_ready  (div_in_ready),
    .in_item   (div_in),
    .out_valid (div_out_valid),
    .out_ready (eno),
    .out_item  (div_out)
  );

  // Output stage: sign, saturation and zero-w override
  logic [2:0][31:0] quo_fix;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (div_out.side.zero) begin
        quo_fix[i] = '0;
      end else if (div_out.side.sat[i]) begin
        quo_fix[i] = div_out.side.neg[i] ? pvp_pkg::SAT_NEG : pvp_pkg::SAT_POS;
      end else if (div_out.side.neg[i]) begin
        quo_fix[i] = -{1'b0, div_out.quo[i]};
      end else begin
        quo_fix[i] = {1'b0, div_out.quo[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eno) begin
      proj.proj_x <= quo_fix[0];
      proj.proj_y <= quo_fix[1];
      proj.proj_z <= quo_fix[2];
      proj.proj_w <= div_out.side.zero ? 32'd0 : div_out.side.cw_out;
      proj.zero_w <= div_out.side.zero;
    end
  end

  assign proj_valid = vo;

  // Checks
  a_zero_quot: assert property (@(posedge clk) disable iff (rst)
    proj_valid && proj.zero_w |-> proj.proj_x == 0 && proj.proj_y == 0 && proj.proj_z == 0)
    else $error("zero w with nonzero quotient");

  a_w_nonzero: assert property (@(posedge clk) disable iff (rst)
    proj_valid && !proj.zero_w |-> proj.proj_w != 0)
    else $error("clip w zero without flag");

  a_s1_zero: assert property (@(posedge clk) disable iff (rst)
    vert_valid && vert_ready |=> v1 && (s1_zero == ($past(vert.vert_z) == 0)))
    else $error("stage 1 zero flag mismatch");

endmodule

// ===== rtl/pvp_div.sv =====
module pvp_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pvp_pkg::div_in_t   in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output pvp_pkg::div_out_t  out_item
);

  typedef struct packed {
    logic [2:0][63:0]               rem;
    logic [2:0][pvp_pkg::QBITS-1:0] quo;
    logic [31:0]                    den;
    pvp_pkg::side_t                 side;
  } stage_t;

  logic [pvp_pkg::QBITS-1:0] v;
  logic [pvp_pkg::QBITS-1:0] en;
  stage_t                    st      [pvp_pkg::QBITS];
  stage_t                    st_next [pvp_pkg::QBITS];

  // Stage enables: a stage moves when empty or when its successor moves
  always_comb begin
    en[pvp_pkg::QBITS-1] = !v[pvp_pkg::QBITS-1] || out_ready;
    for (int k = pvp_pkg::QBITS-2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  // One restoring step per stage, most significant quotient bit first
  always_comb begin
    stage_t      src;
    logic [63:0] trial;
    for (int k = 0; k < pvp_pkg::QBITS; k++) begin
      if (k == 0) begin
        src.rem  = in_item.num;
        src.quo  = '0;
        src.den  = in_item.den;
        src.side = in_item.side;
      end else begin
        src = st[k-1];
      end
      trial = 64'(src.den) << (pvp_pkg::QBITS-1-k);
      st_next[k] = src;
      for (int i = 0; i < 3; i++) begin
        if (src.rem[i] >= trial) begin
          st_next[k].rem[i] = src.rem[i] - trial;
          st_next[k].quo[i][pvp_pkg::QBITS-1-k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < pvp_pkg::QBITS; k++) begin
        if (en[k]) begin
          v[k] <= (k == 0) ? in_valid : v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < pvp_pkg::QBITS; k++) begin
      if (en[k]) begin
        st[k] <= st_next[k];
      end
    end
  end

  assign out_valid     = v[pvp_pkg::QBITS-1];
  assign out_item.quo  = st[pvp_pkg::QBITS-1].quo;
  assign out_item.side = st[pvp_pkg::QBITS-1].side;

endmodule
